FILE: rtl/mpcp_pkg.sv
// ----------------------------------------------------------------------------
// mpcp_pkg
// Shared types and codes for the multichannel pulse-count PWM.
// ----------------------------------------------------------------------------
`default_nettype none

package mpcp_pkg;

   localparam int CHANNELS_DEF = 8;

   localparam logic [2:0] MODE_TICK    = 3'd0;
   localparam logic [2:0] MODE_WRITE   = 3'd1;
   localparam logic [2:0] MODE_READ    = 3'd2;
   localparam logic [2:0] MODE_ENABLE  = 3'd3;
   localparam logic [2:0] MODE_DISABLE = 3'd4;

   localparam logic [1:0] SEL_WIDTH  = 2'd0;
   localparam logic [1:0] SEL_PERIOD = 2'd1;
   localparam logic [1:0] SEL_LEFT   = 2'd2;
   localparam logic [1:0] SEL_COUNT  = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_REJECT   = 2'd1;
   localparam logic [1:0] ST_ALREADY  = 2'd2;

   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] pulse_width;
      logic [31:0] period_len;
      logic [31:0] pulses_left;
      logic [31:0] toggle_count;
      logic [31:0] wait_ticks;
   } entry_type;

   typedef struct packed {
      logic enabled;
      logic level;
      logic parked;
   } flags_type;

endpackage

`default_nettype wire

FILE: rtl/mpcp_ram.sv
// ----------------------------------------------------------------------------
// mpcp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mpcp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/mpcp_update.sv
// ----------------------------------------------------------------------------
// mpcp_update
// Per-channel update: applies one command or one tick to a channel entry.
// ----------------------------------------------------------------------------
`default_nettype none

module mpcp_update (
   input  wire logic [2:0]          op,
   input  wire logic [1:0]          sel,
   input  wire logic [31:0]         value,
   input  wire mpcp_pkg::entry_type cur,
   input  wire mpcp_pkg::flags_type cur_flags,
   output mpcp_pkg::entry_type      nxt,
   output mpcp_pkg::flags_type      nxt_flags,
   output logic [31:0]              rdata,
   output logic [1:0]               status
);

   logic        active;
   logic        fire;
   logic        lvl_n;
   logic [31:0] left_n;
   logic        park;

   always_comb begin
      active = cur_flags.enabled && !cur_flags.parked && (cur.period_len != 32'd0) &&
               (cur.pulse_width <= cur.period_len) && (cur.pulses_left != 32'd0);
      fire   = (cur.wait_ticks <= 32'd1);
      lvl_n  = !cur_flags.level;
      left_n = (cur.pulses_left == mpcp_pkg::ALL_ONES) ? cur.pulses_left
                                                        : cur.pulses_left - 32'd1;
      park   = (cur.pulse_width == 32'd0) || (cur.pulse_width == cur.period_len) ||
               (left_n == 32'd0);

      nxt       = cur;
      nxt_flags = cur_flags;
      rdata     = 32'd0;
      status    = mpcp_pkg::ST_OK;

      case (op)
         mpcp_pkg::MODE_TICK: begin
            if (active) begin
               if (!fire) begin
                  nxt.wait_ticks = cur.wait_ticks - 32'd1;
               end else begin
                  nxt_flags.level  = lvl_n;
                  nxt.toggle_count = cur.toggle_count + 32'd1;
                  nxt.pulses_left  = left_n;
                  if (park) begin
                     nxt_flags.parked = 1'b1;
                     nxt.wait_ticks   = 32'd0;
                  end else begin
                     nxt.wait_ticks = lvl_n ? cur.pulse_width
                                            : cur.period_len - cur.pulse_width;
                  end
               end
            end
         end
         mpcp_pkg::MODE_WRITE: begin
            if (!cur_flags.enabled || sel == mpcp_pkg::SEL_COUNT) begin
               status = mpcp_pkg::ST_REJECT;
            end else begin
               case (sel)
                  mpcp_pkg::SEL_WIDTH: begin
                     if (value <= cur.period_len) begin
                        nxt.pulse_width = value;
                     end
                  end
                  mpcp_pkg::SEL_PERIOD: nxt.period_len  = value;
                  default:              nxt.pulses_left = value;
               endcase
               nxt.wait_ticks   = 32'd0;
               nxt_flags.parked = 1'b0;
            end
         end
         mpcp_pkg::MODE_READ: begin
            if (!cur_flags.enabled) begin
               status = mpcp_pkg::ST_REJECT;
            end else begin
               case (sel)
                  mpcp_pkg::SEL_WIDTH:  rdata = cur.pulse_width;
                  mpcp_pkg::SEL_PERIOD: rdata = cur.period_len;
                  mpcp_pkg::SEL_LEFT:   rdata = cur.pulses_left;
                  default:              rdata = cur.toggle_count;
               endcase
            end
         end
         mpcp_pkg::MODE_ENABLE: begin
            if (cur_flags.enabled) begin
               status = mpcp_pkg::ST_ALREADY;
            end else begin
               nxt_flags.enabled = 1'b1;
               nxt_flags.level   = 1'b0;
               nxt_flags.parked  = 1'b0;
               nxt.pulses_left   = mpcp_pkg::ALL_ONES;
               nxt.wait_ticks    = 32'd0;
            end
         end
         mpcp_pkg::MODE_DISABLE: begin
            if (!cur_flags.enabled) begin
               status = mpcp_pkg::ST_REJECT;
            end else begin
               nxt_flags.enabled = 1'b0;
            end
         end
         default: begin
            status = mpcp_pkg::ST_OK;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/multichannel_pulse_count_pwm.sv
// ----------------------------------------------------------------------------
// multichannel_pulse_count_pwm
// Multichannel PWM with per-channel high time, period and pulse count limit.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one command word: a microsecond tick, a register
//   write, a register read, a channel enable or a channel disable. Every
//   command returns exactly one rsp_ word with all channel levels, read data
//   and status.
//   Channel settings live in one RAM entry per channel with registered read.
//   A tick sweeps the entries one per cycle, read and write-back overlapped;
//   write, read, enable and disable go through read, update and respond
//   steps; a command to a channel out of range or an unknown mode goes
//   straight to the respond step. req_stall is high until the block is
//   back in idle.
//   The response register frees the request side: a new command is taken
//   while the previous word waits on rsp_stall; a finished word waits in the
//   response stage until the output register is free.
//   Reset clears all channels at once through per-entry valid bits; the block
//   takes commands as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_pulse_count_pwm #(
   parameter int CHANNELS = mpcp_pkg::CHANNELS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_mode,
   input  wire logic [2:0]  req_channel,
   input  wire logic [1:0]  req_reg_select,
   input  wire logic [31:0] req_write_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_levels,
   output logic [31:0]      rsp_read_data,
   output logic [1:0]       rsp_status
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CW = $clog2(CHANNELS + 1);
   localparam int EW = $bits(mpcp_pkg::entry_type);
   localparam logic [6:0]    CH_LIM = 7'(CHANNELS);
   localparam logic [CW-1:0] CNT_LAST = CW'(CHANNELS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_CMD  = 3'd2;
   localparam logic [2:0] S_TICK = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [2:0]    mode_ff;
   logic [1:0]    sel_ff;
   logic [31:0]   value_ff;
   logic [AW-1:0] addr_ff;
   logic [CW-1:0] cnt_ff;
   logic          proc_vld_ff;
   logic [AW-1:0] proc_idx_ff;
   logic [31:0]   res_rdata_ff;
   logic [1:0]    res_status_ff;

   logic [CHANNELS-1:0] valid_ff;
   logic [CHANNELS-1:0] enabled_ff;
   logic [CHANNELS-1:0] level_ff;
   logic [CHANNELS-1:0] parked_ff;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_levels_ff;
   logic [31:0] rsp_read_data_ff;
   logic [1:0]  rsp_status_ff;

   logic                req_take;
   logic                rsp_free;
   logic [6:0]          chan_ext;
   logic                chan_ok;
   logic                mode_cmd;
   logic [AW-1:0]       rd_addr;
   logic [AW-1:0]       idx;
   logic                wr_en;
   logic [EW-1:0]       rd_data;
   mpcp_pkg::entry_type cur;
   mpcp_pkg::entry_type nxt;
   mpcp_pkg::flags_type cur_flags;
   mpcp_pkg::flags_type nxt_flags;
   logic [2:0]          op;
   logic [31:0]         upd_rdata;
   logic [1:0]          upd_status;
   logic [7:0]          levels;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign chan_ext  = {4'd0, req_channel};
   assign chan_ok   = (chan_ext < CH_LIM);
   assign mode_cmd  = (req_mode == mpcp_pkg::MODE_WRITE) ||
                      (req_mode == mpcp_pkg::MODE_READ) ||
                      (req_mode == mpcp_pkg::MODE_ENABLE) ||
                      (req_mode == mpcp_pkg::MODE_DISABLE);

   assign rd_addr = (state_ff == S_TICK) ? cnt_ff[AW-1:0] : addr_ff;
   assign idx     = (state_ff == S_CMD) ? addr_ff : proc_idx_ff;
   assign wr_en   = (state_ff == S_CMD) || ((state_ff == S_TICK) && proc_vld_ff);
   assign op      = (state_ff == S_TICK) ? mpcp_pkg::MODE_TICK : mode_ff;

   assign cur               = valid_ff[idx] ? mpcp_pkg::entry_type'(rd_data) : '0;
   assign cur_flags.enabled = enabled_ff[idx];
   assign cur_flags.level   = level_ff[idx];
   assign cur_flags.parked  = parked_ff[idx];

   mpcp_ram #(
      .WIDTH (EW),
      .DEPTH (CHANNELS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx),
      .wr_data (nxt),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mpcp_update u_update (
      .op        (op),
      .sel       (sel_ff),
      .value     (value_ff),
      .cur       (cur),
      .cur_flags (cur_flags),
      .nxt       (nxt),
      .nxt_flags (nxt_flags),
      .rdata     (upd_rdata),
      .status    (upd_status)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_mode == mpcp_pkg::MODE_TICK) begin
                  state_in = S_TICK;
               end else if (mode_cmd && chan_ok) begin
                  state_in = S_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_RD:   state_in = S_CMD;
         S_CMD:  state_in = S_DONE;
         S_TICK: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         proc_vld_ff <= 1'b0;
         valid_ff    <= '0;
         enabled_ff  <= '0;
         level_ff    <= '0;
         parked_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_TICK) begin
            proc_vld_ff <= (cnt_ff < CNT_LAST);
         end else begin
            proc_vld_ff <= 1'b0;
         end
         if (wr_en) begin
            valid_ff[idx]   <= 1'b1;
            enabled_ff[idx] <= nxt_flags.enabled;
            level_ff[idx]   <= nxt_flags.level;
            parked_ff[idx]  <= nxt_flags.parked;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff       <= req_mode;
         sel_ff        <= req_reg_select;
         value_ff      <= req_write_value;
         addr_ff       <= chan_ext[AW-1:0];
         cnt_ff        <= '0;
         res_rdata_ff  <= 32'd0;
         res_status_ff <= (mode_cmd && !chan_ok) ? mpcp_pkg::ST_REJECT : mpcp_pkg::ST_OK;
      end
      if (state_ff == S_TICK) begin
         cnt_ff      <= cnt_ff + CW'(1);
         proc_idx_ff <= cnt_ff[AW-1:0];
      end
      if (state_ff == S_CMD) begin
         res_rdata_ff  <= upd_rdata;
         res_status_ff <= upd_status;
      end
   end

   always_comb begin
      levels = 8'd0;
      for (int i = 0; i < 8; i++) begin
         if (i < CHANNELS) begin
            levels[i] = level_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_DONE) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_DONE) && rsp_free) begin
         rsp_levels_ff    <= levels;
         rsp_read_data_ff <= res_rdata_ff;
         rsp_status_ff    <= res_status_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_levels    = rsp_levels_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multichannel pulse-count PWM testbench
// Sends tick, register write, register read, enable and disable commands
// through the request port and checks every response word, field by field,
// against a cycle-free model of the channel state kept in the bench. A short
// table of directed commands comes first, then random command streams with
// gaps and stalls on both sides, one long response hold-off and one drain midway.
// ----------------------------------------------------------------------------
module testbench;

   localparam int          NUM_CH        = mpcp_pkg::CHANNELS_DEF;
   localparam int          RANDOM_WORDS  = 1125;
   localparam int          STALL_LIMIT   = 3000;
   localparam int          SETTLE_CYCLES = 30;
   localparam logic [2:0]  MODE_SPARE_LO = 3'd5;
   localparam logic [2:0]  MODE_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [7:0]  levels;
      logic [31:0] read_data;
      logic [1:0]  status;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0]   mode;
      logic [2:0]   channel;
      logic [1:0]   reg_select;
      logic [31:0]  write_value;
      logic         typed;
      rsp_word_type answer;
   } stim_row_type;

   localparam rsp_word_type NO_ANSWER = '0;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [2:0]  req_mode        = mpcp_pkg::MODE_TICK;
   logic [2:0]  req_channel     = 3'd0;
   logic [1:0]  req_reg_select  = mpcp_pkg::SEL_WIDTH;
   logic [31:0] req_write_value = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [7:0]  rsp_levels;
   logic [31:0] rsp_read_data;
   logic [1:0]  rsp_status;

   logic        chan_on     [NUM_CH];
   logic [31:0] chan_width  [NUM_CH];
   logic [31:0] chan_period [NUM_CH];
   logic [31:0] chan_left   [NUM_CH];
   logic [31:0] chan_count  [NUM_CH];
   logic        chan_level  [NUM_CH];
   logic [31:0] chan_wait   [NUM_CH];
   logic        chan_parked [NUM_CH];

   rsp_word_type owed_words[$];
   int           failures    = 0;
   int           idle_cycles = 0;
   bit           allow_gaps  = 1'b1;

   stim_row_type directed_rows [25] = '{
      '{mpcp_pkg::MODE_READ,    3'd0, mpcp_pkg::SEL_WIDTH,  32'd0,              1'b1,
        '{8'h00, 32'd0, mpcp_pkg::ST_REJECT}},
      '{mpcp_pkg::MODE_DISABLE, 3'd1, mpcp_pkg::SEL_WIDTH,  32'd0,              1'b1,
        '{8'h00, 32'd0, mpcp_pkg::ST_REJECT}},
      '{mpcp_pkg::MODE_WRITE,   3'd2, mpcp_pkg::SEL_PERIOD, 32'd5,              1'b1,
        '{8'h00, 32'd0, mpcp_pkg::ST_REJECT}},
      '{mpcp_pkg::MODE_TICK,    3'd0, mpcp_pkg::SEL_WIDTH,  32'd0,              1'b1,
        '{8'h00, 32'd0, mpcp_pkg::ST_OK}},
      '{mpcp_pkg::MODE_ENABLE,  3'd0, mpcp_pkg::SEL_WIDTH,  32'd0,              1'b1,
        '{8'h00, 32'd0, mpcp_pkg::ST_OK}},
      '{mpcp_pkg::MODE_ENABLE,  3'd0, mpcp_pkg::SEL_WIDTH,  32'd0,              1'b1,
        '{8'h00, 32'd0, mpcp_pkg::ST_ALREADY}},
      '{mpcp_pkg::MODE_READ,    3'd0, mpcp_pkg::SEL_LEFT,   32'd0,              1'b1,
        '{8'h00, mpcp_pkg::ALL_ONES, mpcp_pkg::ST_OK}},
      '{mpcp_pkg::MODE_WRITE,   3'd0, mpcp_pkg::SEL_COUNT,  mpcp_pkg::ALL_ONES, 1'b1,
        '{8'h00, 32'd0, mpcp_pkg::ST_REJECT}},
      '{mpcp_pkg::MODE_WRITE,   3'd0, mpcp_pkg::SEL_PERIOD, mpcp_pkg::ALL_ONES, 1'b0,
        NO_ANSWER},
      '{mpcp_pkg::MODE_WRITE,   3'd0, mpcp_pkg::SEL_WIDTH,  mpcp_pkg::ALL_ONES, 1'b0,
        NO_ANSWER},
      '{mpcp_pkg::MODE_TICK,    3'd0, mpcp_pkg::SEL_WIDTH,  32'd0, 1'b0, NO_ANSWER},
      '{mpcp_pkg::MODE_READ,    3'd0, mpcp_pkg::SEL_COUNT,  32'd0, 1'b0, NO_ANSWER},
      '{mpcp_pkg::MODE_ENABLE,  3'd7, mpcp_pkg::SEL_WIDTH,  32'd0, 1'b0, NO_ANSWER},
      '{mpcp_pkg::MODE_WRITE,   3'd7, mpcp_pkg::SEL_PERIOD, 32'd3, 1'b0, NO_ANSWER},
      '{mpcp_pkg::MODE_WRITE,   3'd7, mpcp_pkg::SEL_WIDTH,  32'd5, 1'b0, NO_ANSWER},
      '{mpcp_pkg::MODE_WRITE,   3'd7, mpcp_pkg::SEL_LEFT,   32'd0, 1'b0, NO_ANSWER},
      '{mpcp_pkg::MODE_TICK,    3'd0, mpcp_pkg::SEL_WIDTH,  32'd0, 1'b0, NO_ANSWER},
      '{mpcp_pkg::MODE_WRITE,   3'd7, mpcp_pkg::SEL_LEFT,   32'd3, 1'b0, NO_ANSWER},
      '{mpcp_pkg::MODE_WRITE,   3'd7, mpcp_pkg::SEL_WIDTH,  32'd0, 1'b0, NO_ANSWER},
      '{mpcp_pkg::MODE_TICK,    3'd0, mpcp_pkg::SEL_WIDTH,  32'd0, 1'b0, NO_ANSWER},
      '{mpcp_pkg::MODE_TICK,    3'd0, mpcp_pkg::SEL_WIDTH,  32'd0, 1'b0, NO_ANSWER},
      '{mpcp_pkg::MODE_DISABLE, 3'd0, mpcp_pkg::SEL_WIDTH,  32'd0, 1'b0, NO_ANSWER},
      '{mpcp_pkg::MODE_READ,    3'd0, mpcp_pkg::SEL_WIDTH,  32'd0, 1'b0, NO_ANSWER},
      '{MODE_SPARE_HI, 3'd7, mpcp_pkg::SEL_COUNT, mpcp_pkg::ALL_ONES, 1'b0, NO_ANSWER},
      '{MODE_SPARE_LO, 3'd0, mpcp_pkg::SEL_WIDTH, 32'd0,              1'b0, NO_ANSWER}
   };

   multichannel_pulse_count_pwm uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_channel     (req_channel),
      .req_reg_select  (req_reg_select),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_levels      (rsp_levels),
      .rsp_read_data   (rsp_read_data),
      .rsp_status      (rsp_status)
   );

   always #2 clock = ~clock;

   initial begin
      for (int c = 0; c < NUM_CH; c++) begin
         chan_on[c]     = 1'b0;
         chan_width[c]  = '0;
         chan_period[c] = '0;
         chan_left[c]   = '0;
         chan_count[c]  = '0;
         chan_level[c]  = 1'b0;
         chan_wait[c]   = '0;
         chan_parked[c] = 1'b0;
      end
   end

   function automatic void advance_channel(int c);
      if (!chan_on[c] || chan_parked[c] || chan_period[c] == 0 ||
          chan_width[c] > chan_period[c] || chan_left[c] == 0)
         return;
      if (chan_wait[c] != 0)
         chan_wait[c]--;
      if (chan_wait[c] != 0)
         return;
      chan_level[c] = !chan_level[c];
      chan_count[c]++;
      if (chan_left[c] != mpcp_pkg::ALL_ONES)
         chan_left[c]--;
      if (chan_width[c] == 0 || chan_width[c] == chan_period[c] || chan_left[c] == 0) begin
         chan_parked[c] = 1'b1;
         chan_wait[c]   = '0;
      end else begin
         chan_wait[c] = chan_level[c] ? chan_width[c] : chan_period[c] - chan_width[c];
      end
   endfunction

   function automatic rsp_word_type apply_command(logic [2:0] mode, logic [2:0] ch,
                                                  logic [1:0] sel, logic [31:0] val);
      rsp_word_type w;
      w = '0;
      w.status = mpcp_pkg::ST_OK;
      if (mode == mpcp_pkg::MODE_TICK) begin
         for (int c = 0; c < NUM_CH; c++)
            advance_channel(c);
      end else if (mode <= mpcp_pkg::MODE_DISABLE) begin
         if (int'(ch) >= NUM_CH) begin
            w.status = mpcp_pkg::ST_REJECT;
         end else if (mode == mpcp_pkg::MODE_ENABLE) begin
            if (chan_on[ch]) begin
               w.status = mpcp_pkg::ST_ALREADY;
            end else begin
               chan_on[ch]     = 1'b1;
               chan_level[ch]  = 1'b0;
               chan_left[ch]   = mpcp_pkg::ALL_ONES;
               chan_wait[ch]   = '0;
               chan_parked[ch] = 1'b0;
            end
         end else if (!chan_on[ch]) begin
            w.status = mpcp_pkg::ST_REJECT;
         end else if (mode == mpcp_pkg::MODE_DISABLE) begin
            chan_on[ch] = 1'b0;
         end else if (mode == mpcp_pkg::MODE_READ) begin
            case (sel)
               mpcp_pkg::SEL_WIDTH:  w.read_data = chan_width[ch];
               mpcp_pkg::SEL_PERIOD: w.read_data = chan_period[ch];
               mpcp_pkg::SEL_LEFT:   w.read_data = chan_left[ch];
               default:              w.read_data = chan_count[ch];
            endcase
         end else if (sel == mpcp_pkg::SEL_COUNT) begin
            w.status = mpcp_pkg::ST_REJECT;
         end else begin
            if (sel == mpcp_pkg::SEL_WIDTH) begin
               if (val <= chan_period[ch])
                  chan_width[ch] = val;
            end else if (sel == mpcp_pkg::SEL_PERIOD) begin
               chan_period[ch] = val;
            end else begin
               chan_left[ch] = val;
            end
            chan_wait[ch]   = '0;
            chan_parked[ch] = 1'b0;
         end
      end
      for (int c = 0; c < NUM_CH && c < 8; c++)
         w.levels[c] = chan_level[c];
      return w;
   endfunction

   task automatic send_word(input logic [2:0] mode, input logic [2:0] ch,
                            input logic [1:0] sel, input logic [31:0] val,
                            input logic typed, input rsp_word_type answer);
      rsp_word_type w;
      while (allow_gaps && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_channel     <= ch;
      req_reg_select  <= sel;
      req_write_value <= val;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      w = apply_command(mode, ch, sel, val);
      owed_words.push_back(typed ? answer : w);
   endtask

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 70)
         return $urandom_range(8);
      else if (r < 80)
         return mpcp_pkg::ALL_ONES;
      return $urandom();
   endfunction

   initial begin
      int          r;
      logic [2:0]  mode;
      logic [1:0]  sel;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_word(directed_rows[i].mode, directed_rows[i].channel,
                   directed_rows[i].reg_select, directed_rows[i].write_value,
                   directed_rows[i].typed, directed_rows[i].answer);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         allow_gaps = !(n >= 700 && n < 900);
         if (n == 500) begin
            // drain before resuming
            req_valid <= 1'b0;
            while (owed_words.size() != 0)
               @(posedge clock);
         end
         r = $urandom_range(99);
         if (r < 45)
            mode = mpcp_pkg::MODE_TICK;
         else if (r < 65)
            mode = mpcp_pkg::MODE_WRITE;
         else if (r < 78)
            mode = mpcp_pkg::MODE_READ;
         else if (r < 87)
            mode = mpcp_pkg::MODE_ENABLE;
         else if (r < 93)
            mode = mpcp_pkg::MODE_DISABLE;
         else
            mode = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
         sel = 2'($urandom_range(3));
         send_word(mode, 3'($urandom_range(7)), sel, pick_value(), 1'b0, NO_ANSWER);
      end
      req_valid <= 1'b0;
      while (owed_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("multichannel_pulse_count_pwm test passed");
      else
         $display("multichannel_pulse_count_pwm test failed");
      $finish;
   end

   initial begin
      int rx_cycle;
      rx_cycle = 0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (rx_cycle == 1500) begin
            // hold off long enough for the block to back up
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            rx_cycle += 400;
         end
         if (rx_cycle >= 4000 && rx_cycle < 5500)
            rsp_stall <= 1'b0;
         else
            rsp_stall <= ($urandom_range(99) < 23);
      end
   end

   always @(posedge clock) begin
      rsp_word_type owed;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_words.size() == 0) begin
            $error("response word with no command outstanding");
            failures++;
         end else begin
            owed = owed_words.pop_front();
            if (rsp_levels !== owed.levels) begin
               $error("levels: expected %h, got %h", owed.levels, rsp_levels);
               failures++;
            end
            if (rsp_read_data !== owed.read_data) begin
               $error("read_data: expected %h, got %h", owed.read_data, rsp_read_data);
               failures++;
            end
            if (rsp_status !== owed.status) begin
               $error("status: expected %0d, got %0d", owed.status, rsp_status);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("multichannel_pulse_count_pwm test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

FILE: filelist.f
rtl/mpcp_pkg.sv
rtl/mpcp_ram.sv
rtl/mpcp_update.sv
rtl/multichannel_pulse_count_pwm.sv
verif/testbench.sv
